[rtl/cmr_pkg.sv]
package cmr_pkg;

	// input command codes
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_FRAME = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// finish status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	// result kinds
	typedef enum logic {
		KIND_BYTE   = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_OWN_NODE   = 3'd0,
		REG_EXP_SOURCE = 3'd1,
		REG_EXP_TTYPE  = 3'd2,
		REG_EXP_DTYPE  = 3'd3,
		REG_INIT_TID   = 3'd4,
		REG_INIT_CRC   = 3'd5,
		REG_MAX_LENGTH = 3'd6,
		REG_TIMEOUT    = 3'd7
	} cfg_reg_t;

	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [7:0]  RST_OWN_NODE   = 8'd0;
	localparam logic [7:0]  RST_EXP_SOURCE = 8'hFF;
	localparam logic [1:0]  RST_EXP_TTYPE  = 2'd0;
	localparam logic [9:0]  RST_EXP_DTYPE  = 10'd0;
	localparam logic [2:0]  RST_INIT_TID   = 3'd0;
	localparam logic [15:0] RST_INIT_CRC   = 16'hFFFF;
	localparam logic [8:0]  RST_MAX_LENGTH = 9'd256;
	localparam logic [31:0] RST_TIMEOUT    = 32'd1000;

	// source id that accepts any sender and locks on the first frame
	localparam logic [7:0]  SOURCE_ANY = 8'hFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	// first payload lane carrying message bytes
	localparam logic [2:0]  LANE_AFTER_CRC  = 3'd3;
	localparam logic [2:0]  LANE_AFTER_NODE = 3'd1;
	localparam logic [3:0]  MAX_FRAME_LEN   = 4'd8;

	typedef struct packed {
		logic [7:0]  own_node;
		logic [7:0]  exp_source;
		logic [1:0]  exp_ttype;
		logic [9:0]  exp_dtype;
		logic [2:0]  init_tid;
		logic [15:0] init_crc;
		logic [8:0]  max_length;
		logic [31:0] tick_limit;
	} cfg_t;

	// work handed from the front to the back
	typedef struct packed {
		logic        init;      // reload running crc with seed
		logic [15:0] seed;
		logic [2:0]  nbytes;    // message bytes to emit
		logic [2:0]  lane;      // first payload lane to emit
		logic [63:0] data;
		logic [7:0]  base_idx;
		logic        fin;       // finish result follows the bytes
		logic        timeout;
		logic        single;    // transfer had one frame
		logic [15:0] rx_crc;
		logic [8:0]  msg_len;
		logic [7:0]  source;
		logic [2:0]  tid;
	} job_t;

	// one byte of crc-16-ccitt, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/can_multiframe_reassembler_unit.sv]
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------------
// input    | push / full         | cmd, can_id, dlc, frame_data
// result   | empty / pop         | kind, byte_index, byte_value, status,
//          |                     | msg_size, source_node, transfer_id_out, last
// config   | cfg_write           | cfg_index, cfg_data
//
// the front takes one item per cycle while its two-entry job queue has room.
// the back emits a job's bytes one at a time, then a finish result if the job has one;
// a start job only reloads the crc seed, and a dropped frame makes no job at all.
// reset clears all control state.
// a stalled result holds the back while the job queue still absorbs input.
module can_multiframe_reassembler_unit #(
	parameter int MAX_MESSAGE_BYTES     = 256,
	parameter int SERVICE_TIMEOUT_TICKS = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [28:0] can_id,
	input  logic [3:0]  dlc,
	input  logic [63:0] frame_data,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [7:0]  byte_index,
	output logic [7:0]  byte_value,
	output logic [1:0]  status,
	output logic [8:0]  msg_size,
	output logic [7:0]  source_node,
	output logic [2:0]  transfer_id_out,
	output logic        last,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [cmr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cmr_pkg::*;

	localparam int JOB_DEPTH = 2;

	cfg_t cfg_q;
	logic job_push;
	job_t job_in;
	logic job_full;
	logic job_pop;
	job_t job_head;
	logic job_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_node   <= RST_OWN_NODE;
			cfg_q.exp_source <= RST_EXP_SOURCE;
			cfg_q.exp_ttype  <= RST_EXP_TTYPE;
			cfg_q.exp_dtype  <= RST_EXP_DTYPE;
			cfg_q.init_tid   <= RST_INIT_TID;
			cfg_q.init_crc   <= RST_INIT_CRC;
			cfg_q.max_length <= RST_MAX_LENGTH;
			cfg_q.tick_limit <= RST_TIMEOUT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OWN_NODE:   cfg_q.own_node   <= cfg_data[7:0];
				REG_EXP_SOURCE: cfg_q.exp_source <= cfg_data[7:0];
				REG_EXP_TTYPE:  cfg_q.exp_ttype  <= cfg_data[1:0];
				REG_EXP_DTYPE:  cfg_q.exp_dtype  <= cfg_data[9:0];
				REG_INIT_TID:   cfg_q.init_tid   <= cfg_data[2:0];
				REG_INIT_CRC:   cfg_q.init_crc   <= cfg_data[15:0];
				REG_MAX_LENGTH: cfg_q.max_length <= cfg_data[8:0];
				REG_TIMEOUT:    cfg_q.tick_limit <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify
	cmr_front #(
		.MAX_MESSAGE_BYTES     (MAX_MESSAGE_BYTES),
		.SERVICE_TIMEOUT_TICKS (SERVICE_TIMEOUT_TICKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd        (cmd),
		.can_id     (can_id),
		.dlc        (dlc),
		.frame_data (frame_data),
		.cfg        (cfg_q),
		.fifo_full  (job_full),
		.job_push   (job_push),
		.job        (job_in)
	);

	// job queue between front and back
	cmr_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_push),
		.wr_data   (job_in),
		.full      (job_full),
		.rd_en     (job_pop),
		.rd_data   (job_head),
		.not_empty (job_valid)
	);

	// back: emit bytes, crc check, finish
	cmr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (job_valid),
		.job             (job_head),
		.job_pop         (job_pop),
		.pop             (pop),
		.empty           (empty),
		.kind            (kind),
		.byte_index      (byte_index),
		.byte_value      (byte_value),
		.status          (status),
		.msg_size        (msg_size),
		.source_node     (source_node),
		.transfer_id_out (transfer_id_out),
		.last            (last)
	);

	assign full = job_full;

endmodule

[rtl/cmr_job_fifo.sv]
module cmr_job_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cmr_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output cmr_pkg::job_t rd_data,
	output logic          not_empty
);
	import cmr_pkg::*;

	// depth must be a power of two so the pointers wrap on their own; the fifo does not enforce it
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/cmr_front.sv]
module cmr_front #(
	parameter int MAX_MESSAGE_BYTES     = 256,
	parameter int SERVICE_TIMEOUT_TICKS = 1000
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [1:0]    cmd,
	input  logic [28:0]   can_id,
	input  logic [3:0]    dlc,
	input  logic [63:0]   frame_data,
	input  cmr_pkg::cfg_t cfg,
	input  logic          fifo_full,
	output logic          job_push,
	output cmr_pkg::job_t job
);
	import cmr_pkg::*;

	logic        armed_q;
	logic [7:0]  frame_count_q;
	logic [8:0]  byte_count_q;
	logic [15:0] received_crc_q;
	logic [2:0]  cur_tid_q;
	logic [7:0]  locked_src_q;
	logic [31:0] ticks_q;

	logic        armed_n;
	logic [7:0]  frame_count_n;
	logic [8:0]  byte_count_n;
	logic [15:0] received_crc_n;
	logic [2:0]  cur_tid_n;
	logic [7:0]  locked_src_n;
	logic [31:0] ticks_n;

	logic        accept;
	logic [2:0]  id_tid;
	logic        id_last;
	logic [5:0]  id_fidx;
	logic [6:0]  id_src;
	logic [1:0]  id_ttype;
	logic [9:0]  id_dtype;
	logic [3:0]  len_eff;
	logic [8:0]  limit;
	logic        match;

	assign accept   = push && !fifo_full;
	assign id_tid   = can_id[2:0];
	assign id_last  = can_id[3];
	assign id_fidx  = can_id[9:4];
	assign id_src   = can_id[16:10];
	assign id_ttype = can_id[18:17];
	assign id_dtype = can_id[28:19];
	assign len_eff  = (dlc > MAX_FRAME_LEN) ? MAX_FRAME_LEN : dlc;

	// byte limit is the smaller of the register and the buffer size
	always_comb begin
		if (int'(cfg.max_length) > MAX_MESSAGE_BYTES) begin
			limit = 9'(MAX_MESSAGE_BYTES);
		end else begin
			limit = cfg.max_length;
		end
	end

	// frame filter on source, type, data type and target node
	assign match = (locked_src_q == SOURCE_ANY || {1'b0, id_src} == locked_src_q) &&
		(id_ttype == cfg.exp_ttype) && (id_dtype == cfg.exp_dtype) &&
		(frame_data[7:0] == cfg.own_node);

	// classify the item, update control state, build the job
	always_comb begin
		logic [7:0]  fc_eff;
		logic [2:0]  tid_eff;
		logic [7:0]  src_eff;
		logic [15:0] rx_eff;
		logic [31:0] ticks_eff;
		logic [2:0]  lane0;
		logic [3:0]  rem;
		logic [8:0]  avail;
		logic [2:0]  nb;
		logic [7:0]  fc_new;
		logic [8:0]  bc_new;
		logic [31:0] tick_dec;

		armed_n        = armed_q;
		frame_count_n  = frame_count_q;
		byte_count_n   = byte_count_q;
		received_crc_n = received_crc_q;
		cur_tid_n      = cur_tid_q;
		locked_src_n   = locked_src_q;
		ticks_n        = ticks_q;
		job_push       = 1'b0;
		job            = '0;

		fc_eff    = (id_fidx == 6'd0) ? 8'd0 : frame_count_q;
		tid_eff   = (id_fidx == 6'd0) ? id_tid : cur_tid_q;
		src_eff   = (id_fidx == 6'd0 && locked_src_q == SOURCE_ANY) ? {1'b0, id_src}
			: locked_src_q;
		if (fc_eff == 8'd0 && !id_last) begin
			rx_eff    = frame_data[23:8];
			ticks_eff = 32'(SERVICE_TIMEOUT_TICKS);
			lane0     = LANE_AFTER_CRC;
		end else begin
			rx_eff    = received_crc_q;
			ticks_eff = ticks_q;
			lane0     = LANE_AFTER_NODE;
		end
		rem    = (len_eff > {1'b0, lane0}) ? (len_eff - {1'b0, lane0}) : 4'd0;
		avail  = (byte_count_q >= limit) ? 9'd0 : (limit - byte_count_q);
		nb     = ({5'd0, rem} > avail) ? avail[2:0] : rem[2:0];
		fc_new = fc_eff + 8'd1;
		bc_new = byte_count_q + {6'd0, nb};
		tick_dec = (ticks_q != 32'd0) ? (ticks_q - 32'd1) : 32'd0;

		if (accept) begin
			case (cmd)
				CMD_START: begin
					armed_n        = 1'b1;
					frame_count_n  = 8'd0;
					byte_count_n   = 9'd0;
					received_crc_n = 16'd0;
					cur_tid_n      = cfg.init_tid;
					locked_src_n   = cfg.exp_source;
					ticks_n        = cfg.tick_limit;
					job.init       = 1'b1;
					job.seed       = cfg.init_crc;
					job_push       = 1'b1;
				end
				CMD_TICK: begin
					if (armed_q) begin
						ticks_n = tick_dec;
						if (tick_dec == 32'd0) begin
							armed_n     = 1'b0;
							job.fin     = 1'b1;
							job.timeout = 1'b1;
							job.msg_len = byte_count_q;
							job.source  = locked_src_q;
							job.tid     = cur_tid_q;
							job_push    = 1'b1;
						end
					end
				end
				CMD_FRAME: begin
					if (armed_q && len_eff != 4'd0 && match) begin
						frame_count_n = fc_eff;
						cur_tid_n     = tid_eff;
						locked_src_n  = src_eff;
						if (tid_eff == id_tid) begin
							received_crc_n = rx_eff;
							ticks_n        = ticks_eff;
							frame_count_n  = fc_new;
							byte_count_n   = bc_new;
							job.nbytes     = nb;
							job.lane       = lane0;
							job.data       = frame_data;
							job.base_idx   = byte_count_q[7:0];
							job.fin        = id_last;
							job.single     = (fc_new == 8'd1);
							job.rx_crc     = rx_eff;
							job.msg_len    = bc_new;
							job.source     = src_eff;
							job.tid        = tid_eff;
							job_push       = (nb != 3'd0) || id_last;
							if (id_last) begin
								armed_n = 1'b0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// reception state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q        <= 1'b0;
			frame_count_q  <= '0;
			byte_count_q   <= '0;
			received_crc_q <= '0;
			cur_tid_q      <= '0;
			locked_src_q   <= '0;
			ticks_q        <= '0;
		end else begin
			armed_q        <= armed_n;
			frame_count_q  <= frame_count_n;
			byte_count_q   <= byte_count_n;
			received_crc_q <= received_crc_n;
			cur_tid_q      <= cur_tid_n;
			locked_src_q   <= locked_src_n;
			ticks_q        <= ticks_n;
		end
	end

endmodule

[rtl/cmr_back.sv]
module cmr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  cmr_pkg::job_t job,
	output logic          job_pop,
	input  logic          pop,
	output logic          empty,
	output logic          kind,
	output logic [7:0]    byte_index,
	output logic [7:0]    byte_value,
	output logic [1:0]    status,
	output logic [8:0]    msg_size,
	output logic [7:0]    source_node,
	output logic [2:0]    transfer_id_out,
	output logic          last
);
	import cmr_pkg::*;

	logic        cur_valid_q;
	job_t        cur_q;
	logic [2:0]  lane_q;
	logic [2:0]  rem_q;
	logic [7:0]  idx_q;
	logic [15:0] crc_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  byte_index_q;
	logic [7:0]  byte_value_q;
	logic [1:0]  status_q;
	logic [8:0]  msg_size_q;
	logic [7:0]  source_node_q;
	logic [2:0]  transfer_id_q;
	logic        last_q;

	logic        out_free;
	logic        emit_byte;
	logic        emit_fin;
	logic        release_job;
	logic [7:0]  cur_byte;
	logic [1:0]  fin_status;

	assign out_free = !out_valid_q || pop;
	assign cur_byte = cur_q.data[{lane_q, 3'b000} +: 8];

	// finish status from timeout flag, single frame or crc check
	always_comb begin
		if (cur_q.timeout) begin
			fin_status = ST_TIMEOUT;
		end else if (cur_q.single || cur_q.rx_crc == crc_q) begin
			fin_status = ST_OK;
		end else begin
			fin_status = ST_CRC_ERR;
		end
	end

	// step through the current job: seed, bytes, then finish
	always_comb begin
		emit_byte   = 1'b0;
		emit_fin    = 1'b0;
		release_job = 1'b0;
		if (cur_valid_q) begin
			if (cur_q.init) begin
				release_job = 1'b1;
			end else if (rem_q != 3'd0) begin
				if (out_free) begin
					emit_byte   = 1'b1;
					release_job = (rem_q == 3'd1) && !cur_q.fin;
				end
			end else if (out_free) begin
				emit_fin    = 1'b1;
				release_job = 1'b1;
			end
		end
	end

	assign job_pop = job_valid && (!cur_valid_q || release_job);

	// control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				cur_valid_q <= 1'b1;
			end else if (release_job) begin
				cur_valid_q <= 1'b0;
			end
			if (emit_byte || emit_fin) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job progress and running crc
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q  <= job;
			lane_q <= job.lane;
			rem_q  <= job.nbytes;
			idx_q  <= job.base_idx;
		end else if (emit_byte) begin
			lane_q <= lane_q + 3'd1;
			rem_q  <= rem_q - 3'd1;
			idx_q  <= idx_q + 8'd1;
		end
		if (cur_valid_q && cur_q.init) begin
			crc_q <= cur_q.seed;
		end else if (emit_byte) begin
			crc_q <= crc_byte(crc_q, cur_byte);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit_byte) begin
			kind_q        <= KIND_BYTE;
			byte_index_q  <= idx_q;
			byte_value_q  <= cur_byte;
			status_q      <= ST_OK;
			msg_size_q    <= 9'd0;
			source_node_q <= cur_q.source;
			transfer_id_q <= cur_q.tid;
			last_q        <= (rem_q == 3'd1) && !cur_q.fin;
		end else if (emit_fin) begin
			kind_q        <= KIND_FINISH;
			byte_index_q  <= 8'd0;
			byte_value_q  <= 8'd0;
			status_q      <= fin_status;
			msg_size_q    <= cur_q.msg_len;
			source_node_q <= cur_q.source;
			transfer_id_q <= cur_q.tid;
			last_q        <= 1'b1;
		end
	end

	assign empty           = !out_valid_q;
	assign kind            = kind_q;
	assign byte_index      = byte_index_q;
	assign byte_value      = byte_value_q;
	assign status          = status_q;
	assign msg_size        = msg_size_q;
	assign source_node     = source_node_q;
	assign transfer_id_out = transfer_id_q;
	assign last            = last_q;

endmodule

[rtl/cmr_checker.sv]
module cmr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       kind,
	input logic [7:0] byte_index,
	input logic [7:0] byte_value,
	input logic [1:0] status,
	input logic [8:0] msg_size,
	input logic       last
);
	import cmr_pkg::*;

	// nothing waits right after reset
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result present right after reset");

	// a waiting result holds until its transfer
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(byte_index) &&
			$stable(byte_value) && $stable(status) && $stable(last)))
		else $error("stalled result changed");

	// a finish result always closes its input item
	a_finish_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_FINISH) |-> last)
		else $error("finish result without last");

	// byte results carry no status and no length
	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_BYTE) |-> (status == ST_OK && msg_size == 9'd0))
		else $error("byte result with status or length");

	// finish results carry no byte
	a_finish_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_FINISH) |-> (byte_index == 8'd0 && byte_value == 8'd0))
		else $error("finish result with byte data");

endmodule

bind can_multiframe_reassembler_unit cmr_checker u_cmr_checker (.*);

[sim/cmr_reassembly_checker.sv]
`timescale 1ns / 1ps

module cmr_reassembly_checker #(
	parameter int MAX_MESSAGE_BYTES     = 256,
	parameter int SERVICE_TIMEOUT_TICKS = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  cmd,
	input  logic [28:0] can_id,
	input  logic [3:0]  dlc,
	input  logic [63:0] frame_data,
	input  logic        empty,
	input  logic        pop,
	input  logic        kind,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  byte_value,
	input  logic [1:0]  status,
	input  logic [8:0]  msg_size,
	input  logic [7:0]  source_node,
	input  logic [2:0]  transfer_id_out,
	input  logic        last,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [cmr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);
	import cmr_pkg::*;

	typedef struct {
		kind_t      kind;
		logic [7:0] idx;
		logic [7:0] val;
		status_t    st;
		logic [8:0] mlen;
		logic [7:0] src;
		logic [2:0] tid;
		logic       closes_item;
	} reassembly_out_t;

	// register file as the block sees it
	cfg_t        regs;

	// receiver state
	logic        armed;
	logic [7:0]  frame_count;
	logic [8:0]  byte_count;
	logic [15:0] running_crc;
	logic [15:0] received_crc;
	logic [2:0]  cur_tid;
	logic [7:0]  locked_src;
	logic [31:0] ticks_left;

	reassembly_out_t reassembled_q[$];

	// crc-16-ccitt, one bit at a time from the msb
	function automatic logic [15:0] ccitt_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic emit(input kind_t k, input logic [7:0] idx, input logic [7:0] val,
			input status_t st, input logic [8:0] mlen);
		reassembly_out_t o;
		o.kind        = k;
		o.idx         = idx;
		o.val         = val;
		o.st          = st;
		o.mlen        = mlen;
		o.src         = locked_src;
		o.tid         = cur_tid;
		o.closes_item = 1'b0;
		reassembled_q.push_back(o);
	endtask

	// flag the newest result as the final one of its input
	task automatic mark_item_end();
		reassembly_out_t o;
		o = reassembled_q.pop_back();
		o.closes_item = 1'b1;
		reassembled_q.push_back(o);
	endtask

	task automatic reassemble_item(input logic [1:0] c, input logic [28:0] id,
			input logic [3:0] flen, input logic [63:0] d);
		int         lanes;
		int         lane;
		int         limit;
		int         produced;
		logic [2:0] tid;
		logic       lastf;
		logic [5:0] fidx;
		logic [6:0] src;
		logic [1:0] tt;
		logic [9:0] dt;
		status_t    st;

		if (c == CMD_START) begin
			armed        = 1'b1;
			frame_count  = '0;
			byte_count   = '0;
			received_crc = '0;
			running_crc  = regs.init_crc;
			cur_tid      = regs.init_tid;
			locked_src   = regs.exp_source;
			ticks_left   = regs.tick_limit;
			return;
		end
		if (!armed) begin
			return;
		end

		// timer tick
		if (c == CMD_TICK) begin
			if (ticks_left != 0) begin
				ticks_left = ticks_left - 32'd1;
			end
			if (ticks_left == 0) begin
				emit(KIND_FINISH, 8'd0, 8'd0, ST_TIMEOUT, byte_count);
				mark_item_end();
				armed = 1'b0;
			end
			return;
		end
		if (c != CMD_FRAME) begin
			return;
		end

		lanes = (flen > 4'd8) ? 8 : int'(flen);
		if (lanes == 0) begin
			return;
		end

		tid   = id[2:0];
		lastf = id[3];
		fidx  = id[9:4];
		src   = id[16:10];
		tt    = id[18:17];
		dt    = id[28:19];

		// acceptance filter
		if ((locked_src != SOURCE_ANY && {1'b0, src} != locked_src) ||
				tt != regs.exp_ttype || dt != regs.exp_dtype || d[7:0] != regs.own_node) begin
			return;
		end

		if (fidx == 0) begin
			frame_count = '0;
			cur_tid     = tid;
			if (locked_src == SOURCE_ANY) begin
				locked_src = {1'b0, src};
			end
		end
		if (cur_tid != tid) begin
			return;
		end

		// first frame of a multi-frame transfer carries the crc
		if (frame_count == 0 && !lastf) begin
			ticks_left   = SERVICE_TIMEOUT_TICKS;
			received_crc = d[23:8];
			lane         = 3;
		end else begin
			lane = 1;
		end

		limit    = (regs.max_length > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : int'(regs.max_length);
		produced = 0;
		while (lane < lanes && int'(byte_count) < limit) begin
			running_crc = ccitt_step(running_crc, d[8*lane +: 8]);
			emit(KIND_BYTE, byte_count[7:0], d[8*lane +: 8], ST_OK, 9'd0);
			byte_count = byte_count + 9'd1;
			produced++;
			lane++;
		end
		frame_count = frame_count + 8'd1;

		if (lastf) begin
			st = (frame_count == 1 || received_crc == running_crc) ? ST_OK : ST_CRC_ERR;
			emit(KIND_FINISH, 8'd0, 8'd0, st, byte_count);
			produced++;
			armed = 1'b0;
		end
		if (produced > 0) begin
			mark_item_end();
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		reassembly_out_t w;
		if (!arst_n) begin
			regs = {RST_OWN_NODE, RST_EXP_SOURCE, RST_EXP_TTYPE, RST_EXP_DTYPE,
				RST_INIT_TID, RST_INIT_CRC, RST_MAX_LENGTH, RST_TIMEOUT};
			armed        = 1'b0;
			frame_count  = '0;
			byte_count   = '0;
			running_crc  = '0;
			received_crc = '0;
			cur_tid      = '0;
			locked_src   = '0;
			ticks_left   = '0;
			reassembled_q.delete();
			fail_count   = 0;
		end else begin
			// register writes
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_OWN_NODE:   regs.own_node   = cfg_data[7:0];
					REG_EXP_SOURCE: regs.exp_source = cfg_data[7:0];
					REG_EXP_TTYPE:  regs.exp_ttype  = cfg_data[1:0];
					REG_EXP_DTYPE:  regs.exp_dtype  = cfg_data[9:0];
					REG_INIT_TID:   regs.init_tid   = cfg_data[2:0];
					REG_INIT_CRC:   regs.init_crc   = cfg_data[15:0];
					REG_MAX_LENGTH: regs.max_length = cfg_data[8:0];
					REG_TIMEOUT:    regs.tick_limit = cfg_data[31:0];
					default: ;
				endcase
			end

			// input transfer
			if (push && !full) begin
				reassemble_item(cmd, can_id, dlc, frame_data);
			end

			// result transfer
			if (pop && !empty) begin
				if (reassembled_q.size() == 0) begin
					$error("result with nothing expected: kind %0d index %0d value %0h",
						kind, byte_index, byte_value);
					fail_count++;
				end else begin
					w = reassembled_q.pop_front();
					compare_field("kind", 32'(w.kind), 32'(kind));
					compare_field("byte_index", 32'(w.idx), 32'(byte_index));
					compare_field("byte_value", 32'(w.val), 32'(byte_value));
					compare_field("status", 32'(w.st), 32'(status));
					compare_field("msg_size", 32'(w.mlen), 32'(msg_size));
					compare_field("source_node", 32'(w.src), 32'(source_node));
					compare_field("transfer_id_out", 32'(w.tid), 32'(transfer_id_out));
					compare_field("last", 32'(w.closes_item), 32'(last));
				end
			end
		end
		outstanding = reassembled_q.size();
	end

endmodule

[sim/can_multiframe_reassembler_unit_tb.sv]
`timescale 1ns / 1ps

module can_multiframe_reassembler_unit_tb;
	import cmr_pkg::*;

	localparam int MSG_BYTES = 256;
	localparam int SVC_TICKS = 1000;
	// command code the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int HOLD_CYCLES = 400;

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_CRC,
		FLAW_NOISE,
		FLAW_STRAY_TID,
		FLAW_REFIRST,
		FLAW_RESTART,
		FLAW_TIMEOUT
	} flaw_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  cmd;
	logic [28:0] can_id;
	logic [3:0]  dlc;
	logic [63:0] frame_data;
	logic        empty;
	logic        pop;
	logic        kind;
	logic [7:0]  byte_index;
	logic [7:0]  byte_value;
	logic [1:0]  status;
	logic [8:0]  msg_size;
	logic [7:0]  source_node;
	logic [2:0]  transfer_id_out;
	logic        last;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int          fail_count;
	int          outstanding;

	cfg_t        shadow;
	int          items_sent;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_req;
	bit          hold_taken;
	int          hold_left;

	can_multiframe_reassembler_unit #(
		.MAX_MESSAGE_BYTES    (MSG_BYTES),
		.SERVICE_TIMEOUT_TICKS(SVC_TICKS)
	) dut (.*);

	cmr_reassembly_checker #(
		.MAX_MESSAGE_BYTES    (MSG_BYTES),
		.SERVICE_TIMEOUT_TICKS(SVC_TICKS)
	) chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("can_multiframe_reassembler_unit regression: fail");
		$finish;
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		pop        = 1'b0;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [28:0] make_id(input logic [2:0] tid, input logic lastf,
			input logic [5:0] fidx, input logic [6:0] src, input logic [1:0] tt,
			input logic [9:0] dt);
		return {dt, tt, src, fidx, lastf, tid};
	endfunction

	// crc the sender places in the first frame
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		repeat (8) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// one input transfer, with optional sender gap first
	task automatic offer(input logic [1:0] c, input logic [28:0] id, input logic [3:0] len,
			input logic [63:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push       <= 1'b1;
		cmd        <= c;
		can_id     <= id;
		dlc        <= len;
		frame_data <= d;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// wait until every predicted result has come out, then let the block settle
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
		case (r)
			REG_OWN_NODE:   shadow.own_node   = v[7:0];
			REG_EXP_SOURCE: shadow.exp_source = v[7:0];
			REG_EXP_TTYPE:  shadow.exp_ttype  = v[1:0];
			REG_EXP_DTYPE:  shadow.exp_dtype  = v[9:0];
			REG_INIT_TID:   shadow.init_tid   = v[2:0];
			REG_INIT_CRC:   shadow.init_crc   = v[15:0];
			REG_MAX_LENGTH: shadow.max_length = v[8:0];
			REG_TIMEOUT:    shadow.tick_limit = v;
			default: ;
		endcase
	endtask

	task automatic write_all(input cfg_t c);
		write_reg(REG_OWN_NODE, 32'(c.own_node));
		write_reg(REG_EXP_SOURCE, 32'(c.exp_source));
		write_reg(REG_EXP_TTYPE, 32'(c.exp_ttype));
		write_reg(REG_EXP_DTYPE, 32'(c.exp_dtype));
		write_reg(REG_INIT_TID, 32'(c.init_tid));
		write_reg(REG_INIT_CRC, 32'(c.init_crc));
		write_reg(REG_MAX_LENGTH, 32'(c.max_length));
		write_reg(REG_TIMEOUT, c.tick_limit);
		cfg_write <= 1'b0;
	endtask

	function automatic cfg_t pick_setting();
		cfg_t c;
		c.own_node = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
		case ($urandom_range(3))
			0, 1:    c.exp_source = SOURCE_ANY;
			2:       c.exp_source = {1'b0, 7'($urandom)};
			default: c.exp_source = $urandom_range(1) ? 8'h7F : 8'h00;
		endcase
		c.exp_ttype = 2'($urandom);
		c.exp_dtype = 10'($urandom);
		c.init_tid  = 3'($urandom);
		c.init_crc  = 16'($urandom);
		case ($urandom_range(4))
			0:       c.max_length = 9'($urandom_range(0, 12));
			1:       c.max_length = 9'd256;
			default: c.max_length = 9'($urandom_range(0, 256));
		endcase
		case ($urandom_range(3))
			0:       c.tick_limit = 32'($urandom_range(0, 5));
			1:       c.tick_limit = 32'hFFFF_FFFF;
			default: c.tick_limit = 32'd1000;
		endcase
		return c;
	endfunction

	// noise between frames: foreign, empty or misaddressed frames, ticks, bad commands
	task automatic offer_noise(input logic [2:0] tid, input logic [6:0] src);
		logic [63:0] d;
		d = {$urandom, $urandom};
		case ($urandom_range(4))
			0: offer(CMD_FRAME, 29'($urandom), 4'($urandom), d);
			1: offer(CMD_FRAME, make_id(tid, 1'b0, 6'($urandom), src, shadow.exp_ttype,
					shadow.exp_dtype), 4'd0, d);
			2: begin
				d[7:0] = shadow.own_node ^ 8'($urandom_range(1, 255));
				offer(CMD_FRAME, make_id(tid, 1'($urandom_range(1)), 6'($urandom), src,
					shadow.exp_ttype, shadow.exp_dtype), 4'($urandom_range(1, 8)), d);
			end
			3: offer(CMD_TICK, 29'($urandom), 4'($urandom), d);
			default: offer(CMD_UNUSED, 29'($urandom), 4'($urandom), d);
		endcase
	endtask

	// start, then one transfer of n_frames frames, possibly broken on purpose; a timeout flaw sends only ticks
	task automatic send_transfer(input int n_frames, input flaw_t flaw, input bit full_frames);
		logic [2:0]  tid;
		logic [6:0]  src;
		logic [63:0] fdata[$];
		logic [3:0]  flen[$];
		logic [15:0] crc;
		logic [63:0] d;
		logic [3:0]  l;
		logic [5:0]  fidx;
		int          limit;
		int          stored;
		int          lanes;
		int          m;
		int          f;
		int          odd_at;
		int          nticks;

		tid = 3'($urandom);
		src = (shadow.exp_source == SOURCE_ANY) ? 7'($urandom) : shadow.exp_source[6:0];
		offer(CMD_START, 29'($urandom), 4'($urandom), {$urandom, $urandom});

		// tick the start timer; it runs out only when the limit is at most six
		if (flaw == FLAW_TIMEOUT) begin
			if (shadow.tick_limit == 0) begin
				nticks = 1;
			end else if (shadow.tick_limit <= 6) begin
				nticks = int'(shadow.tick_limit);
			end else begin
				nticks = 3;
			end
			repeat (nticks) offer(CMD_TICK, 29'($urandom), 4'($urandom), {$urandom, $urandom});
			return;
		end

		// build the frames and the crc over the bytes the block will keep
		limit  = (shadow.max_length > MSG_BYTES) ? MSG_BYTES : int'(shadow.max_length);
		crc    = shadow.init_crc;
		stored = 0;
		for (f = 0; f < n_frames; f++) begin
			d      = {$urandom, $urandom};
			d[7:0] = shadow.own_node;
			if (full_frames) begin
				l = 4'd8;
			end else if ($urandom_range(9) == 0) begin
				l = 4'($urandom_range(9, 15));
			end else begin
				l = 4'($urandom_range(1, 8));
			end
			fdata.push_back(d);
			flen.push_back(l);
			lanes = (l > 4'd8) ? 8 : int'(l);
			for (m = (f == 0 && n_frames > 1) ? 3 : 1; m < lanes && stored < limit; m++) begin
				crc = crc_add(crc, d[8*m +: 8]);
				stored++;
			end
		end
		if (flaw == FLAW_BAD_CRC) begin
			crc = crc ^ (16'd1 << $urandom_range(15));
		end
		if (n_frames > 1) begin
			d        = fdata[0];
			d[23:8]  = crc;
			fdata[0] = d;
		end

		odd_at = $urandom_range(n_frames - 1);
		for (f = 0; f < n_frames; f++) begin
			if (f == odd_at) begin
				case (flaw)
					FLAW_NOISE: offer_noise(tid, src);
					FLAW_STRAY_TID: offer(CMD_FRAME, make_id(tid ^ 3'($urandom_range(1, 7)),
							1'($urandom_range(1)), 6'($urandom_range(1, 63)), src,
							shadow.exp_ttype, shadow.exp_dtype), flen[f], fdata[f]);
					FLAW_REFIRST: if (f > 0) begin
						offer(CMD_FRAME, make_id(tid, 1'b0, 6'd0, src, shadow.exp_ttype,
							shadow.exp_dtype), flen[0], fdata[0]);
					end
					FLAW_RESTART: offer(CMD_START, 29'($urandom), 4'($urandom),
							{$urandom, $urandom});
					default: ;
				endcase
			end
			fidx = (f == 0) ? 6'd0 : 6'($urandom_range(1, 63));
			offer(CMD_FRAME, make_id(tid, f == n_frames - 1, fidx, src, shadow.exp_ttype,
				shadow.exp_dtype), flen[f], fdata[f]);
			if ($urandom_range(11) == 0) begin
				offer(CMD_TICK, 29'($urandom), 4'($urandom), {$urandom, $urandom});
			end
		end
	endtask

	function automatic flaw_t pick_flaw();
		int r;
		r = $urandom_range(99);
		if (r < 55) return FLAW_NONE;
		if (r < 65) return FLAW_BAD_CRC;
		if (r < 75) return FLAW_NOISE;
		if (r < 82) return FLAW_STRAY_TID;
		if (r < 88) return FLAW_REFIRST;
		if (r < 93) return FLAW_RESTART;
		return FLAW_TIMEOUT;
	endfunction

	initial begin
		cfg_t        c;
		int          target;
		int          n_done;
		logic [63:0] ones;

		arst_n        = 1'b0;
		push          = 1'b0;
		cmd           = CMD_START;
		can_id        = '0;
		dlc           = '0;
		frame_data    = '0;
		cfg_write     = 1'b0;
		cfg_index     = REG_OWN_NODE;
		cfg_data      = '0;
		hold_req      = 1'b0;
		items_sent    = 0;
		send_idle_pct = 22;
		recv_idle_pct = 81;
		ones          = '1;
		shadow = {RST_OWN_NODE, RST_EXP_SOURCE, RST_EXP_TTYPE, RST_EXP_DTYPE,
			RST_INIT_TID, RST_INIT_CRC, RST_MAX_LENGTH, RST_TIMEOUT};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not armed yet: frames, ticks and unknown codes do nothing
		offer(CMD_FRAME, make_id(3'd0, 1'b1, 6'd0, 7'd5, 2'd0, 10'd0), 4'd8, 64'd0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_UNUSED, '0, '0, '0);
		offer(CMD_START, '0, '0, '0);
		offer(CMD_UNUSED, '1, '1, ones);
		// empty frame, then a frame for another node
		offer(CMD_FRAME, make_id(3'd0, 1'b1, 6'd0, 7'd5, 2'd0, 10'd0), 4'd0, 64'd0);
		offer(CMD_FRAME, make_id(3'd0, 1'b1, 6'd0, 7'd5, 2'd0, 10'd0), 4'd8, 64'h01);
		// restart while armed, short first frame locks source 127
		offer(CMD_START, '0, '0, '0);
		offer(CMD_FRAME, make_id(3'd5, 1'b0, 6'd0, 7'h7F, 2'd0, 10'd0), 4'd2,
			64'h0000_0000_00BE_EF00);
		// long frame, stray transfer id, foreign source
		offer(CMD_FRAME, make_id(3'd5, 1'b0, 6'd1, 7'h7F, 2'd0, 10'd0), 4'd15,
			64'hFFFF_FFFF_FFFF_FF00);
		offer(CMD_FRAME, make_id(3'd4, 1'b0, 6'd2, 7'h7F, 2'd0, 10'd0), 4'd8, 64'h1234_5600);
		offer(CMD_FRAME, make_id(3'd5, 1'b0, 6'd2, 7'd3, 2'd0, 10'd0), 4'd8, 64'h1234_5600);
		// second first frame keeps appending, last frame checks crc
		offer(CMD_FRAME, make_id(3'd5, 1'b0, 6'd0, 7'h7F, 2'd0, 10'd0), 4'd8,
			64'hA5C3_0F96_7E81_4200);
		offer(CMD_FRAME, make_id(3'd5, 1'b1, 6'd63, 7'h7F, 2'd0, 10'd0), 4'd4, 64'h5A_3C00);
		// single frame of zeros, then an all-ones identifier that is filtered
		offer(CMD_START, '0, '0, '0);
		offer(CMD_FRAME, make_id(3'd0, 1'b1, 6'd0, 7'd0, 2'd0, 10'd0), 4'd8, 64'd0);
		offer(CMD_START, '0, '0, '0);
		offer(CMD_FRAME, '1, 4'd8, ones);
		drain();

		// extreme register values; a zero timeout ends on the first tick
		c = {8'hFF, 8'h00, 2'd3, 10'h3FF, 3'd7, 16'h0000, 9'd0, 32'd0};
		write_all(c);
		offer(CMD_START, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		drain();
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		cfg_write <= 1'b0;
		offer(CMD_START, '0, '0, '0);
		offer(CMD_TICK, '0, '0, '0);
		offer(CMD_FRAME, make_id(3'd7, 1'b1, 6'd0, 7'd0, 2'd3, 10'h3FF), 4'd8, ones);

		// random phases: receiver idle, then sender idle, then no idling
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 81 : 0;
			recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 22 : 0;
			target = items_sent + ITEMS_PER_PHASE;
			n_done = 0;
			while (items_sent < target) begin
				if (n_done % 8 == 0) begin
					drain();
					c = pick_setting();
					if (ph == 2 && n_done == 0) begin
						c.max_length = 9'd256;
					end
					write_all(c);
				end
				if (ph == 2 && n_done == 0) begin
					// long message under a held-off receiver fills the block
					hold_req = 1'b1;
					send_transfer(40, FLAW_NONE, 1'b1);
				end else begin
					send_transfer(($urandom_range(3) == 0) ? 1 : $urandom_range(2, 5),
						pick_flaw(), 1'b0);
				end
				n_done++;
			end
		end

		push <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("can_multiframe_reassembler_unit regression: pass");
		end else begin
			$display("can_multiframe_reassembler_unit regression: fail");
		end
		$finish;
	end

endmodule
